[rtl/core/lir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants for limb_integer_to_residues
// Widths, register indexes, sequencer states, queue item and the modular fold.
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int MAX_MODULI  = 4;
   localparam int MAX_LIMBS   = 8;
   localparam int LIMB_W      = 56;
   localparam int MOD_W       = 63;
   localparam int IDX_W       = $clog2(MAX_MODULI);
   localparam int NM_W        = 3;
   localparam int NL_W        = 4;
   localparam int POS_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = MOD_W;
   localparam int SRC_W       = 64;
   localparam int CNT_W       = $clog2(SRC_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_MODULI      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMBS_PER_CHUNK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_0       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_1       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_2       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_3       = 3'd5;

   // 2^56 as a plain value in the 64-bit shift word
   localparam logic [SRC_W-1:0] RADIX_WORD = 64'h0100_0000_0000_0000;

   typedef logic [MAX_MODULI-1:0][MOD_W-1:0] mod_array_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMB,   // limb mod m
      ST_POW,    // power mod m
      ST_MUL1,   // limb * power
      ST_RES,    // residue mod m
      ST_ADD,    // residue + term
      ST_RAD,    // 2^56 mod m
      ST_MUL2,   // power * 2^56
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [LIMB_W-1:0] limb_value;
      logic              final_chunk;
      logic              emit;
      logic [IDX_W-1:0]  last_index;
   } item_type;

   // s < 2m assumed: one conditional subtract
   function automatic logic [MOD_W-1:0] mod_fold(input logic [SRC_W-1:0] s,
                                                 input logic [MOD_W-1:0] m);
      logic [SRC_W-1:0] mm;
      logic [SRC_W-1:0] r;
      mm = {1'b0, m};
      r  = (s >= mm) ? (s - mm) : s;
      return r[MOD_W-1:0];
   endfunction

endpackage

[rtl/core/limb_integer_to_residues.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limb_integer_to_residues: multi-limb integer to residue reduction
// 56-bit limbs in, one residue per configured modulus out per large integer.
// ----------------------------------------------------------------------------
// Sequencing: per modulus, six 64-step bit-serial reductions/multiplies,
//   of which the two modular multiplies take an extra add phase per bit,
//   plus the add state; the single shared shift-and-fold unit runs them
//   for each of the N moduli in use (1..4), one limb at a time.
// Output: the residues of a completed integer leave one per cycle
//   while rsp_ready is high.
// Reset (synchronous, active high): queue empty, powers one, residues zero,
//   registers at one modulus, one limb, every modulus two.
// ----------------------------------------------------------------------------
module limb_integer_to_residues (
   input  logic                             clock,
   input  logic                             reset,
   // limb intake
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lir_pkg::LIMB_W-1:0]       req_limb_value,
   input  logic                             req_final_chunk,
   // residues
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lir_pkg::MOD_W-1:0]        rsp_residue,
   output logic [lir_pkg::IDX_W-1:0]        rsp_modulus_index,
   output logic                             rsp_end_of_stream,
   output logic                             rsp_last_of_run,
   // register writes
   input  logic                             csr_write_enable,
   input  logic [lir_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lir_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // configuration registers
   logic [lir_pkg::NM_W-1:0]    num_moduli_ff, num_moduli_in;
   logic [lir_pkg::NL_W-1:0]    limbs_ff, limbs_in;
   lir_pkg::mod_array_type      moduli_ff, moduli_in;
   logic [lir_pkg::CSR_IDX_W-1:0] mod_off;

   // front to queue to back
   logic              push, full, pop, q_valid;
   lir_pkg::item_type push_item, head;

   assign mod_off = csr_index - lir_pkg::CSR_MODULUS_0;

   always_comb begin
      num_moduli_in = num_moduli_ff;
      limbs_in      = limbs_ff;
      moduli_in     = moduli_ff;
      if (csr_write_enable) begin
         unique case (csr_index) inside
            lir_pkg::CSR_NUM_MODULI: begin
               num_moduli_in = csr_write_data[lir_pkg::NM_W-1:0];
            end
            lir_pkg::CSR_LIMBS_PER_CHUNK: begin
               limbs_in = csr_write_data[lir_pkg::NL_W-1:0];
            end
            lir_pkg::CSR_MODULUS_0, lir_pkg::CSR_MODULUS_1,
            lir_pkg::CSR_MODULUS_2, lir_pkg::CSR_MODULUS_3: begin
               moduli_in[mod_off[lir_pkg::IDX_W-1:0]] = csr_write_data;
            end
            default: ;   // writes beyond the map are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_moduli_ff <= lir_pkg::NM_W'(1);
         limbs_ff      <= lir_pkg::NL_W'(1);
         for (int i = 0; i < lir_pkg::MAX_MODULI; i++) begin
            moduli_ff[i] <= lir_pkg::MOD_W'(2);
         end
      end else begin
         num_moduli_ff <= num_moduli_in;
         limbs_ff      <= limbs_in;
         moduli_ff     <= moduli_in;
      end
   end

   // intake: counts limbs and marks the one that completes an integer
   lir_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_limb_value  (req_limb_value),
      .req_final_chunk (req_final_chunk),
      .num_moduli      (num_moduli_ff),
      .limbs_per_chunk (limbs_ff),
      .q_full          (full),
      .q_push          (push),
      .q_item          (push_item)
   );

   // lets intake take the next limb while the sequencer grinds
   lir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .valid     (q_valid),
      .head      (head)
   );

   // per-modulus reduce, multiply, accumulate, then emit from output reg
   lir_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (head),
      .q_pop             (pop),
      .moduli            (moduli_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_residue       (rsp_residue),
      .rsp_modulus_index (rsp_modulus_index),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

[rtl/core/lir_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_front: limb intake
// Tracks limb position and tags each item with emit flag and last modulus index.
// ----------------------------------------------------------------------------
module lir_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lir_pkg::LIMB_W-1:0]      req_limb_value,
   input  logic                            req_final_chunk,
   input  logic [lir_pkg::NM_W-1:0]        num_moduli,
   input  logic [lir_pkg::NL_W-1:0]        limbs_per_chunk,
   input  logic                            q_full,
   output logic                            q_push,
   output lir_pkg::item_type               q_item
);

   logic [lir_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [lir_pkg::NL_W-1:0]  nl_eff;
   logic [lir_pkg::NL_W-1:0]  pos_next;
   logic [lir_pkg::IDX_W-1:0] last_idx;
   logic                      emit;

   always_comb begin
      if (limbs_per_chunk == '0) begin
         nl_eff = lir_pkg::NL_W'(1);
      end else if (limbs_per_chunk > lir_pkg::NL_W'(lir_pkg::MAX_LIMBS)) begin
         nl_eff = lir_pkg::NL_W'(lir_pkg::MAX_LIMBS);
      end else begin
         nl_eff = limbs_per_chunk;
      end
      if (num_moduli == '0) begin
         last_idx = '0;
      end else if (num_moduli > lir_pkg::NM_W'(lir_pkg::MAX_MODULI)) begin
         last_idx = lir_pkg::IDX_W'(lir_pkg::MAX_MODULI - 1);
      end else begin
         last_idx = lir_pkg::IDX_W'(num_moduli - lir_pkg::NM_W'(1));
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign pos_next  = {1'b0, pos_ff} + lir_pkg::NL_W'(1);
   assign emit      = (pos_next >= nl_eff);
   assign pos_in    = emit ? '0 : pos_next[lir_pkg::POS_W-1:0];

   assign q_item.limb_value  = req_limb_value;
   assign q_item.final_chunk = req_final_chunk;
   assign q_item.emit        = emit;
   assign q_item.last_index  = last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (q_push) begin
         pos_ff <= pos_in;
      end
   end

endmodule

[rtl/core/lir_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_queue: item queue between intake and sequencer
// Small flop FIFO of tagged limbs.
// ----------------------------------------------------------------------------
module lir_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lir_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output lir_pkg::item_type head
);

   lir_pkg::item_type              mem_ff [lir_pkg::QUEUE_DEPTH];
   logic [lir_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [lir_pkg::QPTR_W:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == (lir_pkg::QPTR_W+1)'(lir_pkg::QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/lir_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_back: residue sequencer
// Bit-serial modular reduce / multiply per modulus, residue store and output.
// ----------------------------------------------------------------------------
module lir_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  lir_pkg::item_type             q_item,
   output logic                          q_pop,
   input  lir_pkg::mod_array_type        moduli,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lir_pkg::MOD_W-1:0]     rsp_residue,
   output logic [lir_pkg::IDX_W-1:0]     rsp_modulus_index,
   output logic                          rsp_end_of_stream,
   output logic                          rsp_last_of_run
);

   localparam int MW = lir_pkg::MOD_W;
   localparam int SW = lir_pkg::SRC_W;

   lir_pkg::state_type state_ff, state_in;

   lir_pkg::item_type              item_ff, item_in;
   logic [lir_pkg::IDX_W-1:0]      k_ff, k_in;
   logic [SW-1:0]                  src_ff, src_in;
   logic [MW-1:0]                  acc_ff, acc_in;
   logic [MW-1:0]                  mcand_ff, mcand_in;
   logic [MW-1:0]                  a_ff, a_in;
   logic [MW-1:0]                  p_ff, p_in;
   logic [lir_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                           phase_ff, phase_in;
   logic [MW-1:0]                  power_ff [lir_pkg::MAX_MODULI];
   logic [MW-1:0]                  power_in [lir_pkg::MAX_MODULI];
   logic [MW-1:0]                  res_ff [lir_pkg::MAX_MODULI];
   logic [MW-1:0]                  res_in [lir_pkg::MAX_MODULI];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]                  rsp_res_ff, rsp_res_in;
   logic [lir_pkg::IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic                           rsp_eos_ff, rsp_eos_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [MW-1:0] m_raw, m;
   logic          is_mul, add_phase, inbit, shift, step_done, out_free, k_last;
   logic [MW-1:0] dbl, addv, step_val;

   assign m_raw = moduli[k_ff];
   assign m     = (m_raw < MW'(2)) ? MW'(2) : m_raw;

   assign is_mul    = (state_ff == lir_pkg::ST_MUL1) || (state_ff == lir_pkg::ST_MUL2);
   assign add_phase = is_mul && phase_ff;
   assign inbit     = !is_mul && src_ff[SW-1];
   assign shift     = !is_mul || phase_ff;
   assign step_done = (cnt_ff == '0) && shift;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign k_last    = (k_ff == item_ff.last_index);

   // double (plus incoming bit) and add, each folded once
   assign dbl      = lir_pkg::mod_fold({acc_ff, inbit}, m);
   assign addv     = lir_pkg::mod_fold({1'b0, acc_ff} + {1'b0, mcand_ff}, m);
   assign step_val = add_phase ? (src_ff[SW-1] ? addv : acc_ff) : dbl;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         lir_pkg::ST_IDLE: begin
            if (q_valid) state_in = lir_pkg::ST_LIMB;
         end
         lir_pkg::ST_LIMB: begin
            if (step_done) state_in = lir_pkg::ST_POW;
         end
         lir_pkg::ST_POW: begin
            if (step_done) state_in = lir_pkg::ST_MUL1;
         end
         lir_pkg::ST_MUL1: begin
            if (step_done) state_in = lir_pkg::ST_RES;
         end
         lir_pkg::ST_RES: begin
            if (step_done) state_in = lir_pkg::ST_ADD;
         end
         lir_pkg::ST_ADD: begin
            state_in = lir_pkg::ST_RAD;
         end
         lir_pkg::ST_RAD: begin
            if (step_done) state_in = lir_pkg::ST_MUL2;
         end
         lir_pkg::ST_MUL2: begin
            if (step_done) begin
               if (!k_last) state_in = lir_pkg::ST_LIMB;
               else if (item_ff.emit) state_in = lir_pkg::ST_EMIT;
               else state_in = lir_pkg::ST_IDLE;
            end
         end
         lir_pkg::ST_EMIT: begin
            if (out_free && k_last) state_in = lir_pkg::ST_IDLE;
         end
         default: state_in = lir_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in      = item_ff;
      k_in         = k_ff;
      src_in       = src_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      a_in         = a_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      power_in     = power_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      rsp_res_in   = rsp_res_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_eos_in   = rsp_eos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff) inside
         lir_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               k_in     = '0;
               acc_in   = '0;
               cnt_in   = '1;
               phase_in = 1'b0;
               src_in   = {{(SW-lir_pkg::LIMB_W){1'b0}}, q_item.limb_value};
            end
         end
         lir_pkg::ST_LIMB, lir_pkg::ST_POW, lir_pkg::ST_MUL1,
         lir_pkg::ST_RES, lir_pkg::ST_RAD, lir_pkg::ST_MUL2: begin
            acc_in   = step_val;
            phase_in = is_mul && !phase_ff;
            if (shift) begin
               src_in = {src_ff[SW-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
            end
            if (step_done) begin
               acc_in   = '0;
               cnt_in   = '1;
               phase_in = 1'b0;
               case (state_ff)
                  lir_pkg::ST_LIMB: begin
                     a_in   = step_val;
                     src_in = {1'b0, power_ff[k_ff]};
                  end
                  lir_pkg::ST_POW: begin
                     p_in     = step_val;
                     mcand_in = a_ff;
                     src_in   = {1'b0, step_val};
                  end
                  lir_pkg::ST_MUL1: begin
                     mcand_in = step_val;
                     src_in   = {1'b0, res_ff[k_ff]};
                  end
                  lir_pkg::ST_RES: begin
                     acc_in = step_val;
                  end
                  lir_pkg::ST_RAD: begin
                     a_in     = step_val;
                     mcand_in = p_ff;
                     src_in   = {1'b0, step_val};
                  end
                  default: begin
                     power_in[k_ff] = step_val;
                     if (!k_last) begin
                        k_in   = k_ff + 1'b1;
                        src_in = {{(SW-lir_pkg::LIMB_W){1'b0}}, item_ff.limb_value};
                     end else begin
                        k_in = '0;
                     end
                  end
               endcase
            end
         end
         lir_pkg::ST_ADD: begin
            res_in[k_ff] = addv;
            acc_in       = '0;
            cnt_in       = '1;
            phase_in     = 1'b0;
            src_in       = lir_pkg::RADIX_WORD;
         end
         lir_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff[k_ff];
               rsp_idx_in   = k_ff;
               rsp_eos_in   = item_ff.final_chunk;
               rsp_last_in  = k_last;
               if (k_last) begin
                  for (int i = 0; i < lir_pkg::MAX_MODULI; i++) begin
                     power_in[i] = MW'(1);
                     res_in[i]   = '0;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lir_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < lir_pkg::MAX_MODULI; i++) begin
            power_ff[i] <= MW'(1);
            res_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         power_ff     <= power_in;
         res_ff       <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      src_ff      <= src_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      a_ff        <= a_in;
      p_ff        <= p_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_eos_ff  <= rsp_eos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_residue       = rsp_res_ff;
   assign rsp_modulus_index = rsp_idx_ff;
   assign rsp_end_of_stream = rsp_eos_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

[rtl/core/lir_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_checker: port-level checks for limb_integer_to_residues
// Watches the result channel over time.
// ----------------------------------------------------------------------------
module lir_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lir_pkg::MOD_W-1:0]     rsp_residue,
   input logic [lir_pkg::IDX_W-1:0]     rsp_modulus_index,
   input logic                          rsp_last_of_run
);

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residue))
      else $error("stalled residue changed");

   // nothing to show right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // the highest modulus slot always closes a run
   a_top_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_modulus_index == lir_pkg::IDX_W'(lir_pkg::MAX_MODULI - 1))
      |-> rsp_last_of_run)
      else $error("top modulus index not marked last");

   // a run never restarts at index zero before its last residue
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run
      |=> !(rsp_valid && rsp_modulus_index == '0))
      else $error("run restarted before its last residue");

endmodule

bind limb_integer_to_residues lir_checker u_lir_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_residue       (rsp_residue),
   .rsp_modulus_index (rsp_modulus_index),
   .rsp_last_of_run   (rsp_last_of_run)
);
